FILE: rtl/integer_to_radix_digits_defines.svh
// Assertion macros used by the checker module.
`ifndef INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define I2RD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("i2rd check failed");

// The antecedent implies the consequent in the next cycle.
`define I2RD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("i2rd check failed");

`endif

FILE: rtl/i2rd_pkg.sv
`default_nettype none
package i2rd_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int MAX_SYMBOLS    = 16;
    localparam int ADDR_W         = 5;
    localparam int CFG_DATA_W     = 64;
    localparam int RADIX_W        = 5;
    localparam int REM_W          = 4;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [7:0]         MINUS_CHAR  = 8'h2D;

    typedef enum logic [1:0] {
        REG_RADIX    = 2'd0,
        REG_ALPHA_LO = 2'd1,
        REG_ALPHA_HI = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic load_input;
        logic div_step;
        logic store_digit;
        logic load_sign;
        logic read_digit;
        logic load_digit;
        logic dec_index;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic conv_done;
        logic neg;
        logic index_zero;
        logic out_taken;
    } status_t;

endpackage
`default_nettype wire

FILE: rtl/i2rd_regs.sv
`default_nettype none
module i2rd_regs
    import i2rd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic      [CFG_DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic      [RADIX_W-1:0]     radix_eff,
    output logic      [63:0]            alpha_lo,
    output logic      [63:0]            alpha_hi
);

    logic [RADIX_W-1:0] radix_reg;
    logic [63:0]        alpha_lo_reg;
    logic [63:0]        alpha_hi_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg    <= RADIX_RESET;
            alpha_lo_reg <= '0;
            alpha_hi_reg <= '0;
        end else if (wr_en) begin
            case (paddr[4:3])
                REG_RADIX:    radix_reg    <= pwdata[RADIX_W-1:0];
                REG_ALPHA_LO: alpha_lo_reg <= pwdata;
                REG_ALPHA_HI: alpha_hi_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_RADIX:    prdata = {{(CFG_DATA_W-RADIX_W){1'b0}}, radix_reg};
            REG_ALPHA_LO: prdata = alpha_lo_reg;
            REG_ALPHA_HI: prdata = alpha_hi_reg;
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        if (radix_reg < RADIX_W'(2)) begin
            radix_eff = RADIX_W'(2);
        end else if (radix_reg > RADIX_W'(MAX_SYMBOLS)) begin
            radix_eff = RADIX_W'(MAX_SYMBOLS);
        end else begin
            radix_eff = radix_reg;
        end
    end

    assign alpha_lo = alpha_lo_reg;
    assign alpha_hi = alpha_hi_reg;

endmodule
`default_nettype wire

FILE: rtl/i2rd_ctrl.sv
`default_nettype none
module i2rd_ctrl
    import i2rd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIGIT,
        ST_SIGN,
        ST_WAIT_SIGN,
        ST_FETCH,
        ST_EMIT,
        ST_WAIT_DIGIT
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready_reg) begin
                        state_reg    <= ST_DIV;
                        s_tready_reg <= 1'b0;
                    end
                end
                ST_DIV: begin
                    if (status.div_last) begin
                        state_reg <= ST_DIGIT;
                    end
                end
                ST_DIGIT: begin
                    if (!status.conv_done) begin
                        state_reg <= ST_DIV;
                    end else if (status.neg) begin
                        state_reg <= ST_SIGN;
                    end else begin
                        state_reg <= ST_FETCH;
                    end
                end
                ST_SIGN:      state_reg <= ST_WAIT_SIGN;
                ST_WAIT_SIGN: begin
                    if (status.out_taken) begin
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:     state_reg <= ST_EMIT;
                ST_EMIT:      state_reg <= ST_WAIT_DIGIT;
                ST_WAIT_DIGIT: begin
                    if (status.out_taken) begin
                        if (status.index_zero) begin
                            state_reg    <= ST_IDLE;
                            s_tready_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                default: begin
                    state_reg    <= ST_IDLE;
                    s_tready_reg <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        cmd             = '0;
        cmd.load_input  = (state_reg == ST_IDLE) && s_tvalid && s_tready_reg;
        cmd.div_step    = (state_reg == ST_DIV);
        cmd.store_digit = (state_reg == ST_DIGIT);
        cmd.load_sign   = (state_reg == ST_SIGN);
        cmd.read_digit  = (state_reg == ST_FETCH);
        cmd.load_digit  = (state_reg == ST_EMIT);
        cmd.dec_index   = (state_reg == ST_WAIT_DIGIT) && status.out_taken
                          && !status.index_zero;
    end

    assign s_tready = s_tready_reg;

endmodule
`default_nettype wire

FILE: rtl/i2rd_dp.sv
`default_nettype none
module i2rd_dp
    import i2rd_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic [RADIX_W-1:0]    radix_eff,
    input  wire logic [63:0]           alpha_lo,
    input  wire logic [63:0]           alpha_hi,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [7:0]            character,
    output logic                       last
);

    localparam int IW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] mag_reg;
    logic                  neg_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [IW-1:0]         bit_cnt_reg;
    logic [CW-1:0]         cnt_reg;
    logic [IW-1:0]         idx_reg;
    logic [REM_W-1:0]      rdata_reg;
    logic [REM_W-1:0]      digit_mem [VALUE_BITS];
    logic                  m_tvalid_reg;
    logic [7:0]            char_reg;
    logic                  last_reg;

    logic [RADIX_W-1:0]    trial;
    logic                  ge;
    logic [RADIX_W-1:0]    diff;
    logic [63:0]           word;
    logic [7:0]            symbol;

    assign trial = {rem_reg, mag_reg[VALUE_BITS-1]};
    assign ge    = trial >= radix_eff;
    assign diff  = trial - radix_eff;
    assign word  = rdata_reg[3] ? alpha_hi : alpha_lo;
    assign symbol = word[{rdata_reg[2:0], 3'b000} +: 8];

    always_ff @(posedge aclk) begin
        if (cmd.load_input) begin
            neg_reg <= value[VALUE_BITS-1];
            mag_reg <= value[VALUE_BITS-1] ? (VALUE_BITS'(0) - value) : value;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            mag_reg <= {mag_reg[VALUE_BITS-2:0], ge};
            rem_reg <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        end else if (cmd.store_digit) begin
            rem_reg <= '0;
        end
        if (cmd.store_digit) begin
            digit_mem[cnt_reg[IW-1:0]] <= rem_reg;
        end
        if (cmd.read_digit) begin
            rdata_reg <= digit_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
        end else begin
            if (cmd.load_input || cmd.store_digit) begin
                bit_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            if (cmd.load_input) begin
                cnt_reg <= '0;
            end else if (cmd.store_digit) begin
                cnt_reg <= cnt_reg + 1'b1;
                idx_reg <= cnt_reg[IW-1:0];
            end else if (cmd.dec_index) begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_sign || cmd.load_digit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sign) begin
            char_reg <= MINUS_CHAR;
            last_reg <= 1'b0;
        end else if (cmd.load_digit) begin
            char_reg <= symbol;
            last_reg <= (idx_reg == '0);
        end
    end

    always_comb begin
        status            = '0;
        status.div_last   = (bit_cnt_reg == IW'(VALUE_BITS - 1));
        status.conv_done  = (mag_reg == '0) || (cnt_reg == CW'(VALUE_BITS - 1));
        status.neg        = neg_reg;
        status.index_zero = (idx_reg == '0);
        status.out_taken  = m_tvalid_reg && m_tready;
    end

    assign m_tvalid  = m_tvalid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

FILE: rtl/integer_to_radix_digits.sv
// Converts one signed integer per item into text, one character per result item.
// The D digits are computed one after another on the shared bit-serial radix divider.
// After the last digit, a minus sign is sent first for a negative value; each digit is then
// read from the digit memory and registered for output, most significant digit first.
// A new item is accepted only after the last character of the previous item has been taken.
// Reset is synchronous, active low: control idles, radix becomes 10, both alphabets clear.
`default_nettype none
module integer_to_radix_digits
    import i2rd_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: value.
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // Fields from bit 0: character.
    output logic      [7:0]                m_tdata,
    output logic                           m_tlast,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [CFG_DATA_W-1:0]     pwdata,
    output logic      [CFG_DATA_W-1:0]     prdata,
    output logic                           pready
);

    logic [RADIX_W-1:0] radix_eff;
    logic [63:0]        alpha_lo;
    logic [63:0]        alpha_hi;
    cmd_t               cmd;
    status_t            status;

    i2rd_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .radix_eff (radix_eff),
        .alpha_lo  (alpha_lo),
        .alpha_hi  (alpha_hi)
    );

    i2rd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    i2rd_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .value     (s_tdata[VALUE_BITS-1:0]),
        .radix_eff (radix_eff),
        .alpha_lo  (alpha_lo),
        .alpha_hi  (alpha_hi),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .character (m_tdata),
        .last      (m_tlast)
    );

endmodule
`default_nettype wire

FILE: rtl/i2rd_checker.sv
`default_nettype none
`include "integer_to_radix_digits_defines.svh"
module i2rd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    `I2RD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `I2RD_ASSERT_NEXT(a_ready_after_last, m_tvalid && m_tready && m_tlast, s_tready)
    `I2RD_ASSERT_NOW(a_no_output_when_ready, s_tready, !m_tvalid)
    `I2RD_ASSERT_NEXT(a_output_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind integer_to_radix_digits i2rd_checker u_i2rd_checker (.*);
`default_nettype wire
